@@ hdl/srf_pkg.sv @@
// Shared types and constants for the sliding window rank filter.
package srf_pkg;

    localparam int MAX_HALF_DEF  = 3;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_ROWS_DEF  = 4096;

    localparam int PIX_W = 8;
    localparam int LW_W  = 12;
    localparam int HW_W  = 2;
    localparam int RK_W  = 6;
    localparam int CFG_IW = 2;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST  = 12'd640;
    localparam logic [HW_W-1:0] HALF_WINDOW_RST = 2'd1;
    localparam logic [RK_W-1:0] RANK_RST        = 6'd4;

    localparam int QDEPTH = 8;

    typedef enum logic [CFG_IW-1:0] {
        REG_LINE_WIDTH  = 2'd0,
        REG_HALF_WINDOW = 2'd1,
        REG_RANK        = 2'd2
    } t_reg;

    typedef struct packed {
        logic act;
        logic res;
    } t_ctl;

endpackage

@@ hdl/srf_front.sv @@
// Front end: configuration, pixel position, line stores and window register.
module srf_front #(
    parameter int MAX_HALF  = srf_pkg::MAX_HALF_DEF,
    parameter int MAX_WIDTH = srf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = srf_pkg::MAX_ROWS_DEF,
    localparam int SIDE  = 2 * MAX_HALF + 1,
    localparam int N     = SIDE * SIDE,
    localparam int LINES = 2 * MAX_HALF,
    localparam int LB    = $clog2(LINES),
    localparam int XW    = $clog2(MAX_WIDTH),
    localparam int YW    = $clog2(MAX_ROWS),
    localparam int HB    = $clog2(MAX_HALF + 1),
    localparam int CW    = $clog2(N)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [srf_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [srf_pkg::LW_W-1:0]      i_cfg_data,
    input  logic                          i_accept,
    input  logic [srf_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_frame_start,
    output srf_pkg::t_ctl                 o_ctl1,
    output srf_pkg::t_ctl                 o_ctl2,
    output logic [N-1:0][srf_pkg::PIX_W-1:0] o_win,
    output logic [HB-1:0]                 o_h,
    output logic [CW-1:0]                 o_sel,
    output logic [XW-1:0]                 o_cx,
    output logic [YW-1:0]                 o_cy
);

    localparam int WW  = XW + 1;
    localparam int CWD = (WW > srf_pkg::LW_W) ? WW : srf_pkg::LW_W;
    localparam int HX  = (HB > srf_pkg::HW_W) ? HB : srf_pkg::HW_W;
    localparam int SW  = (CW > srf_pkg::RK_W) ? CW : srf_pkg::RK_W;
    localparam int NW  = 2 * HB + 2;

    logic [srf_pkg::LW_W-1:0] r_line_width;
    logic [srf_pkg::HW_W-1:0] r_half;
    logic [srf_pkg::RK_W-1:0] r_rank;

    logic [XW-1:0] r_col, n_col;
    logic [YW-1:0] r_row, n_row;
    logic [LB-1:0] r_slot, n_slot;

    logic [CWD-1:0] lw_x, w_c;
    logic [WW-1:0]  w;
    logic [HX-1:0]  hx;
    logic [HB-1:0]  h;
    logic [XW-1:0]  x;
    logic [YW-1:0]  y;
    logic [LB-1:0]  slot;
    logic           pre_wrap, post_wrap, post_new;
    logic [YW-1:0]  pre_row, post_row;
    logic [LB-1:0]  pre_slot, post_slot;
    logic           res;
    logic [HB:0]    side;
    logic [NW-1:0]  n_cells;
    logic [SW-1:0]  rk, nn, sel_c;

    srf_pkg::t_ctl  r_ctl1, r_ctl2;
    logic [srf_pkg::PIX_W-1:0] r_px1;
    logic [LB-1:0]  r_slot1;
    logic [HB-1:0]  r_h1, r_h2;
    logic [CW-1:0]  r_sel1, r_sel2;
    logic [XW-1:0]  r_cx1, r_cx2;
    logic [YW-1:0]  r_cy1, r_cy2;

    logic [srf_pkg::PIX_W-1:0] r_rd [LINES];
    logic [SIDE-1:0][srf_pkg::PIX_W-1:0] col;
    logic [N-1:0][srf_pkg::PIX_W-1:0]    r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= srf_pkg::LINE_WIDTH_RST;
            r_half       <= srf_pkg::HALF_WINDOW_RST;
            r_rank       <= srf_pkg::RANK_RST;
        end else if (i_cfg_valid) begin
            case (srf_pkg::t_reg'(i_cfg_index))
                srf_pkg::REG_LINE_WIDTH:  r_line_width <= i_cfg_data;
                srf_pkg::REG_HALF_WINDOW: r_half <= i_cfg_data[srf_pkg::HW_W-1:0];
                srf_pkg::REG_RANK:        r_rank <= i_cfg_data[srf_pkg::RK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lw_x = CWD'(r_line_width);
        if (lw_x == '0) begin
            w_c = CWD'(1);
        end else if (lw_x > CWD'(MAX_WIDTH)) begin
            w_c = CWD'(MAX_WIDTH);
        end else begin
            w_c = lw_x;
        end
        w = w_c[WW-1:0];

        hx = (HX'(r_half) > HX'(MAX_HALF)) ? HX'(MAX_HALF) : HX'(r_half);
        h  = hx[HB-1:0];

        pre_wrap = (({1'b0, r_row} + 1'b1) == (YW+1)'(MAX_ROWS));
        pre_row  = pre_wrap ? '0 : r_row + 1'b1;
        pre_slot = (pre_wrap || r_slot == LB'(LINES - 1)) ? '0 : r_slot + 1'b1;

        if (i_frame_start) begin
            x = '0; y = '0; slot = '0;
        end else if ({1'b0, r_col} >= w) begin
            x = '0; y = pre_row; slot = pre_slot;
        end else begin
            x = r_col; y = r_row; slot = r_slot;
        end

        post_wrap = (({1'b0, y} + 1'b1) == (YW+1)'(MAX_ROWS));
        post_row  = post_wrap ? '0 : y + 1'b1;
        post_slot = (post_wrap || slot == LB'(LINES - 1)) ? '0 : slot + 1'b1;
        post_new  = (({1'b0, x} + 1'b1) >= w);

        n_col  = post_new ? '0 : x + 1'b1;
        n_row  = post_new ? post_row : y;
        n_slot = post_new ? post_slot : slot;

        res = (x >= XW'({h, 1'b0})) && (y >= YW'({h, 1'b0}));

        side    = {h, 1'b1};
        n_cells = {{(HB+1){1'b0}}, side} * {{(HB+1){1'b0}}, side};
        rk      = SW'(r_rank);
        nn      = SW'(n_cells);
        sel_c   = (rk < nn) ? rk : nn - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            if (i_accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_slot <= n_slot;
            end
            r_ctl1 <= '{act: i_accept, res: i_accept & res};
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_px1   <= i_pixel;
            r_slot1 <= slot;
            r_h1    <= h;
            r_sel1  <= sel_c[CW-1:0];
            r_cx1   <= x - XW'(h);
            r_cy1   <= y - YW'(h);
        end
        if (r_ctl1.act) begin
            r_win  <= {r_win[N-SIDE-1:0], col};
            r_h2   <= r_h1;
            r_sel2 <= r_sel1;
            r_cx2  <= r_cx1;
            r_cy2  <= r_cy1;
        end
    end

    for (genvar s = 0; s < LINES; s++) begin : g_line
        logic [srf_pkg::PIX_W-1:0] mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (i_accept) begin
                if (slot == LB'(s)) begin
                    mem[x] <= i_pixel;
                end
                r_rd[s] <= mem[x];
            end
        end
    end

    // row y-r lives r slots before the slot of row y, mod LINES
    always_comb begin
        int idx;
        idx = 0;
        col = '0;
        col[0] = r_px1;
        for (int r = 1; r < SIDE; r++) begin
            idx = int'(r_slot1) - r;
            if (idx < 0) begin
                idx = idx + LINES;
            end
            for (int s = 0; s < LINES; s++) begin
                if (idx == s) begin
                    col[r] = r_rd[s];
                end
            end
        end
    end

    assign o_ctl1 = r_ctl1;
    assign o_ctl2 = r_ctl2;
    assign o_win  = r_win;
    assign o_h    = r_h2;
    assign o_sel  = r_sel2;
    assign o_cx   = r_cx2;
    assign o_cy   = r_cy2;

endmodule

@@ hdl/srf_rank.sv @@
// Back end: rank selection over the window by pairwise compare and count.
module srf_rank #(
    parameter int MAX_HALF  = srf_pkg::MAX_HALF_DEF,
    parameter int MAX_WIDTH = srf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = srf_pkg::MAX_ROWS_DEF,
    localparam int SIDE = 2 * MAX_HALF + 1,
    localparam int N    = SIDE * SIDE,
    localparam int XW   = $clog2(MAX_WIDTH),
    localparam int YW   = $clog2(MAX_ROWS),
    localparam int HB   = $clog2(MAX_HALF + 1),
    localparam int CW   = $clog2(N)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [N-1:0][srf_pkg::PIX_W-1:0] i_win,
    input  logic [HB-1:0]                    i_h,
    input  logic [CW-1:0]                    i_sel,
    input  logic [XW-1:0]                    i_cx,
    input  logic [YW-1:0]                    i_cy,
    output logic                             o_v3,
    output logic                             o_push,
    output logic [srf_pkg::PIX_W-1:0]        o_value,
    output logic [XW-1:0]                    o_cx,
    output logic [YW-1:0]                    o_cy
);

    logic [N-1:0]         act;
    logic [N-1:0][N-1:0]  lt;

    logic                 r_v3, r_v4;
    logic [N-1:0][N-1:0]  r_lt3;
    logic [N-1:0][srf_pkg::PIX_W-1:0] r_val3, r_val4;
    logic [N-1:0]         r_act3, r_act4;
    logic [CW-1:0]        r_sel3, r_sel4;
    logic [XW-1:0]        r_cx3, r_cx4;
    logic [YW-1:0]        r_cy3, r_cy4;
    logic [N-1:0][CW-1:0] r_pos4;

    // ties broken by cell index so every active cell has a distinct position
    always_comb begin
        int c;
        int r;
        c = 0;
        r = 0;
        for (int i = 0; i < N; i++) begin
            c = i / SIDE;
            r = i % SIDE;
            act[i] = (c <= int'({i_h, 1'b0})) && (r <= int'({i_h, 1'b0}));
        end
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                lt[i][j] = act[j] && ((i_win[j] < i_win[i]) ||
                           ((i_win[j] == i_win[i]) && (j < i)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lt3  <= lt;
        r_val3 <= i_win;
        r_act3 <= act;
        r_sel3 <= i_sel;
        r_cx3  <= i_cx;
        r_cy3  <= i_cy;
        for (int i = 0; i < N; i++) begin
            r_pos4[i] <= CW'($countones(r_lt3[i]));
        end
        r_val4 <= r_val3;
        r_act4 <= r_act3;
        r_sel4 <= r_sel3;
        r_cx4  <= r_cx3;
        r_cy4  <= r_cy3;
    end

    always_comb begin
        o_value = '0;
        for (int i = 0; i < N; i++) begin
            if (r_act4[i] && r_pos4[i] == r_sel4) begin
                o_value = o_value | r_val4[i];
            end
        end
    end

    assign o_v3   = r_v3;
    assign o_push = r_v4;
    assign o_cx   = r_cx4;
    assign o_cy   = r_cy4;

endmodule

@@ hdl/srf_queue.sv @@
// Result queue between the rank pipeline and the output port.
module srf_queue #(
    parameter int DEPTH = srf_pkg::QDEPTH,
    parameter int DW    = 8,
    localparam int PB   = $clog2(DEPTH),
    localparam int CB   = PB + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty,
    output logic [CB-1:0] o_count
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PB-1:0] r_wr, r_rd;
    logic [CB-1:0] r_cnt;
    logic          do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PB'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PB'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CB'(i_push) - CB'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

@@ hdl/sliding_window_rank_filter.sv @@
// Top level of the sliding window rank filter.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  input    | push / full              | i_pixel, i_frame_start
//  result   | empty / pop              | o_filtered_value, o_center_x, o_center_y
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One pixel per clock sustained while full is low; a result passes through the line
// store read, window shift, compare, count and queue write stages to the outputs.
// full rises when queued plus in-flight results reach the 8-entry queue depth.
// Reset is synchronous; it clears position, pipeline flags and the queue and restores config defaults.
// Line stores are not cleared; no clearing pass.
module sliding_window_rank_filter #(
    parameter int MAX_HALF  = srf_pkg::MAX_HALF_DEF,
    parameter int MAX_WIDTH = srf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = srf_pkg::MAX_ROWS_DEF,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_ROWS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [srf_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_frame_start,
    output logic                          empty,
    input  logic                          pop,
    output logic [srf_pkg::PIX_W-1:0]     o_filtered_value,
    output logic [XW-1:0]                 o_center_x,
    output logic [YW-1:0]                 o_center_y,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [srf_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [srf_pkg::LW_W-1:0]      i_cfg_data
);

    localparam int SIDE = 2 * MAX_HALF + 1;
    localparam int N    = SIDE * SIDE;
    localparam int HB   = $clog2(MAX_HALF + 1);
    localparam int CW   = $clog2(N);
    localparam int DW   = srf_pkg::PIX_W + XW + YW;
    localparam int CB   = $clog2(srf_pkg::QDEPTH) + 1;
    localparam int TB   = CB + 1;

    logic                accept;
    srf_pkg::t_ctl       ctl1, ctl2;
    logic [N-1:0][srf_pkg::PIX_W-1:0] win;
    logic [HB-1:0]       h2;
    logic [CW-1:0]       sel2;
    logic [XW-1:0]       cx2, cx_r;
    logic [YW-1:0]       cy2, cy_r;
    logic                v3, rpush;
    logic [srf_pkg::PIX_W-1:0] val_r;
    logic [DW-1:0]       q_out;
    logic [CB-1:0]       q_cnt;
    logic [TB-1:0]       total;

    assign total = TB'(q_cnt) + TB'(ctl1.res) + TB'(ctl2.res) + TB'(v3) + TB'(rpush);
    assign full   = (total >= TB'(srf_pkg::QDEPTH));
    assign accept = push && !full;
    assign o_cfg_ready = 1'b1;

    srf_front #(
        .MAX_HALF(MAX_HALF), .MAX_WIDTH(MAX_WIDTH), .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_accept(accept), .i_pixel(i_pixel), .i_frame_start(i_frame_start),
        .o_ctl1(ctl1), .o_ctl2(ctl2), .o_win(win), .o_h(h2), .o_sel(sel2),
        .o_cx(cx2), .o_cy(cy2)
    );

    srf_rank #(
        .MAX_HALF(MAX_HALF), .MAX_WIDTH(MAX_WIDTH), .MAX_ROWS(MAX_ROWS)
    ) u_rank (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(ctl2.res),
        .i_win(win), .i_h(h2), .i_sel(sel2), .i_cx(cx2), .i_cy(cy2),
        .o_v3(v3), .o_push(rpush), .o_value(val_r), .o_cx(cx_r), .o_cy(cy_r)
    );

    srf_queue #(
        .DEPTH(srf_pkg::QDEPTH), .DW(DW)
    ) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(rpush),
        .i_data({val_r, cx_r, cy_r}), .i_pop(pop),
        .o_data(q_out), .o_empty(empty), .o_count(q_cnt)
    );

    assign o_filtered_value = q_out[DW-1 -: srf_pkg::PIX_W];
    assign o_center_x       = q_out[YW +: XW];
    assign o_center_y       = q_out[YW-1:0];

endmodule

@@ hdl/srf_checker.sv @@
// Port-level checker for the sliding window rank filter, with its bind.
module srf_checker #(
    parameter int MAX_WIDTH = srf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = srf_pkg::MAX_ROWS_DEF,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_ROWS)
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic [srf_pkg::PIX_W-1:0] o_filtered_value,
    input logic [XW-1:0]             o_center_x,
    input logic [YW-1:0]             o_center_y
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty ##1 empty ##1 empty ##1 empty)
        else $error("result shown too soon after reset");

    a_reset_not_full: assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("full after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_filtered_value) &&
                              $stable(o_center_x) && $stable(o_center_y)))
        else $error("waiting result changed");

endmodule

bind sliding_window_rank_filter srf_checker #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_ROWS(MAX_ROWS)
) u_srf_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the sliding window rank filter.
`timescale 1ns / 1ps

module tb_top;

    localparam int LINES = 2 * srf_pkg::MAX_HALF_DEF;
    localparam int SIDE  = 2 * srf_pkg::MAX_HALF_DEF + 1;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [7:0]  value;
        logic [10:0] cx;
        logic [11:0] cy;
    } t_rank_out;

    class rank_scoreboard;
        logic [7:0]  rows_mem [LINES][srf_pkg::MAX_WIDTH_DEF];
        logic [7:0]  win [SIDE][SIDE];
        int          col_pos;
        int          row_pos;
        int          lw;
        int          hw;
        int          rk;
        t_rank_out   rank_q[$];
        int          errs;
        int          checked;

        function new();
            col_pos = 0;
            row_pos = 0;
            lw = int'(srf_pkg::LINE_WIDTH_RST);
            hw = int'(srf_pkg::HALF_WINDOW_RST);
            rk = int'(srf_pkg::RANK_RST);
            errs = 0;
            checked = 0;
            foreach (rows_mem[i, j]) rows_mem[i][j] = '0;
            foreach (win[i, j]) win[i][j] = '0;
        endfunction

        function void set_reg(srf_pkg::t_reg idx, logic [11:0] d);
            case (idx)
                srf_pkg::REG_LINE_WIDTH:  lw = int'(d);
                srf_pkg::REG_HALF_WINDOW: hw = int'(d[1:0]);
                srf_pkg::REG_RANK:        rk = int'(d[5:0]);
                default: ;
            endcase
        endfunction

        function int pending();
            return rank_q.size();
        endfunction

        function void note_input(logic [7:0] pix, logic fs);
            int w, h, x, y, sel;
            logic [7:0] vals[$];
            t_rank_out e;
            w = (lw == 0) ? 1 : (lw > srf_pkg::MAX_WIDTH_DEF ? srf_pkg::MAX_WIDTH_DEF : lw);
            h = (hw > srf_pkg::MAX_HALF_DEF) ? srf_pkg::MAX_HALF_DEF : hw;
            if (fs) begin
                col_pos = 0;
                row_pos = 0;
            end else if (col_pos >= w) begin
                col_pos = 0;
                row_pos = (row_pos + 1) % srf_pkg::MAX_ROWS_DEF;
            end
            x = col_pos;
            y = row_pos;
            for (int c = SIDE - 1; c > 0; c--) win[c] = win[c-1];
            win[0][0] = pix;
            for (int r = 1; r < SIDE; r++)
                win[0][r] = rows_mem[(y + srf_pkg::MAX_ROWS_DEF * LINES - r) % LINES][x];
            rows_mem[y % LINES][x] = pix;
            col_pos = x + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = (y + 1) % srf_pkg::MAX_ROWS_DEF;
            end
            if (x < 2 * h || y < 2 * h) return;
            for (int c = 0; c < 2 * h + 1; c++)
                for (int r = 0; r < 2 * h + 1; r++)
                    vals = {vals, win[c][r]};
            vals.sort();
            sel = (rk < vals.size()) ? rk : vals.size() - 1;
            e.value = vals[sel];
            e.cx = 11'(x - h);
            e.cy = 12'(y - h);
            rank_q = {rank_q, e};
        endfunction

        function void check(logic [7:0] v, logic [10:0] cx, logic [11:0] cy);
            t_rank_out e;
            checked++;
            if (rank_q.size() == 0) begin
                errs++;
                if (errs <= 10)
                    $display("unexpected result: value %0d x %0d y %0d", v, cx, cy);
                return;
            end
            e = rank_q.pop_front();
            if (v !== e.value || cx !== e.cx || cy !== e.cy) begin
                errs++;
                if (errs <= 10)
                    $display("mismatch: exp value %0d x %0d y %0d, got value %0d x %0d y %0d",
                             e.value, e.cx, e.cy, v, cx, cy);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_pixel = '0;
    logic        i_frame_start = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_filtered_value;
    logic [10:0] o_center_x;
    logic [11:0] o_center_y;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = srf_pkg::REG_LINE_WIDTH;
    logic [11:0] i_cfg_data = '0;

    rank_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 1'b0;
    bit  held = 1'b0;
    int  hold_cnt = 0;
    int  gap_cnt = 0;

    always #5 i_clk = ~i_clk;

    sliding_window_rank_filter u_dut (
        .i_clk, .i_rst_n, .push, .full, .i_pixel, .i_frame_start,
        .empty, .pop, .o_filtered_value, .o_center_x, .o_center_y,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off to fill the queue
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) sb.check(o_filtered_value, o_center_x, o_center_y);
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else if (!held && sb.checked >= 100) begin
                held = 1'b1;
                hold_cnt = 400;
                pop <= 1'b0;
            end else if (gap_cnt > 0) begin
                gap_cnt--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap_cnt = $urandom_range(0, 5);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send(logic [7:0] pix, logic fs);
        if (!calm && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel <= pix;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_input(pix, fs);
    endtask

    task automatic write_reg(srf_pkg::t_reg idx, logic [11:0] d);
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    task automatic setup(int w, int h, int r);
        write_reg(srf_pkg::REG_LINE_WIDTH, 12'(w));
        write_reg(srf_pkg::REG_HALF_WINDOW, 12'(h));
        write_reg(srf_pkg::REG_RANK, 12'(r));
    endtask

    // noisy frames get extreme pixels and stray frame starts
    task automatic frame(int n, bit fs_first, bit noisy);
        logic [7:0] pix;
        logic       fs;
        for (int i = 0; i < n; i++) begin
            fs = (i == 0 && fs_first) || (noisy && $urandom_range(0, 60) == 0);
            pix = 8'($urandom);
            if (noisy && $urandom_range(0, 7) == 0) pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            send(pix, fs);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of pixels, ranks and radius
        setup(5, 1, 0);
        for (int i = 0; i < 20; i++) send((i % 3 == 0) ? 8'hFF : 8'h00, i == 0);
        setup(5, 1, 63);
        frame(15, 1, 0);
        setup(7, 3, 48);
        frame(49, 1, 0);
        setup(0, 0, 0);
        frame(6, 1, 0);

        // width lowered mid-row: new row begins before the pixel
        setup(20, 1, 4);
        frame(65, 1, 0);
        write_reg(srf_pkg::REG_LINE_WIDTH, 12'd4);
        frame(40, 0, 0);

        // all-ones width clamps to the widest line
        setup(12'hFFF, 0, 0);
        frame(100, 1, 0);

        for (int p = 0; p < 10; p++) begin
            setup($urandom_range(1, 24), $urandom_range(0, 3), $urandom_range(0, 63));
            frame($urandom_range(60, 110), 1, 1);
        end

        // steady stream, no idling
        calm = 1'b1;
        setup(8, 1, 4);
        frame(100, 1, 0);

        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errs == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
